### rtl/xmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xmt_pkg;

   typedef enum logic [4:0] {
      SM_OUT       = 5'd0,
      SM_TEXT      = 5'd1,
      SM_LT        = 5'd2,
      SM_BANG      = 5'd3,
      SM_BANG_DASH = 5'd4,
      SM_COMMENT   = 5'd5,
      SM_COM_D1    = 5'd6,
      SM_COM_D2    = 5'd7,
      SM_DECL      = 5'd8,
      SM_PI        = 5'd9,
      SM_PI_Q      = 5'd10,
      SM_ETAG_NAME = 5'd11,
      SM_ETAG_REST = 5'd12,
      SM_STAG_NAME = 5'd13,
      SM_ATTR_WS   = 5'd14,
      SM_SLASH     = 5'd15,
      SM_ANAME     = 5'd16,
      SM_ANAME_WS  = 5'd17,
      SM_EQ        = 5'd18,
      SM_VALUE     = 5'd19
   } scan_mode_type;

   typedef enum logic [2:0] {
      ROLE_MARKUP     = 3'd0,
      ROLE_TEXT       = 3'd1,
      ROLE_START_NAME = 3'd2,
      ROLE_END_NAME   = 3'd3,
      ROLE_ATTR_NAME  = 3'd4,
      ROLE_ATTR_VALUE = 3'd5
   } role_type;

   typedef enum logic [2:0] {
      EV_NONE        = 3'd0,
      EV_TEXT_BEFORE = 3'd1,
      EV_TEXT_WITH   = 3'd2,
      EV_START_DONE  = 3'd3,
      EV_EMPTY_DONE  = 3'd4,
      EV_END_DONE    = 3'd5
   } token_event_type;

   typedef struct packed {
      scan_mode_type scan_mode;
      logic          quote_dbl;
      logic          error_seen;
   } scan_state_type;

   typedef struct packed {
      role_type        role;
      token_event_type token_event;
      logic            attr_done;
      logic            error_flag;
      logic            doc_done;
   } scan_result_type;

   localparam logic [7:0] CH_LT    = 8'h3c;
   localparam logic [7:0] CH_GT    = 8'h3e;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_QUEST = 8'h3f;
   localparam logic [7:0] CH_DASH  = 8'h2d;
   localparam logic [7:0] CH_EQ    = 8'h3d;
   localparam logic [7:0] CH_DQUOT = 8'h22;
   localparam logic [7:0] CH_SQUOT = 8'h27;

   function automatic logic is_name_byte(input logic [7:0] c);
      return (c inside {[8'h61:8'h7a], [8'h41:8'h5a], [8'h30:8'h39],
                        8'h3a, 8'h5f, 8'h2d, 8'h2e});
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      return (c inside {8'h20, [8'h09:8'h0d]});
   endfunction

endpackage

`default_nettype wire

### rtl/xmt_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module xmt_scan (
   input  xmt_pkg::scan_state_type  cur_state,
   input  logic [7:0]               doc_byte,
   input  logic                     doc_last,
   output xmt_pkg::scan_state_type  next_state,
   output xmt_pkg::scan_result_type result
);
   import xmt_pkg::*;

   // Tag content between attributes.
   scan_mode_type   al_mode;
   role_type        al_role;
   token_event_type al_ev;
   logic            al_err;

   always_comb begin
      al_mode = SM_ATTR_WS;
      al_role = ROLE_MARKUP;
      al_ev   = EV_NONE;
      al_err  = 1'b0;
      if (is_ws(doc_byte)) begin
         al_mode = SM_ATTR_WS;
      end else if (doc_byte == CH_GT) begin
         al_ev   = EV_START_DONE;
         al_mode = SM_OUT;
      end else if (doc_byte == CH_SLASH) begin
         al_mode = SM_SLASH;
      end else if (is_name_byte(doc_byte)) begin
         al_role = ROLE_ATTR_NAME;
         al_mode = SM_ANAME;
      end else begin
         al_mode = cur_state.scan_mode;
         al_err  = 1'b1;
      end
   end

   always_comb begin
      scan_state_type  nxt;
      role_type        role;
      token_event_type ev;
      logic            ad;
      logic            err;
      logic            done;

      nxt  = cur_state;
      role = ROLE_MARKUP;
      ev   = EV_NONE;
      ad   = 1'b0;
      err  = 1'b0;
      done = 1'b0;

      if (!cur_state.error_seen) begin
         case (cur_state.scan_mode)
            SM_OUT, SM_TEXT: begin
               if (doc_byte == CH_LT) begin
                  if (cur_state.scan_mode == SM_TEXT) ev = EV_TEXT_BEFORE;
                  nxt.scan_mode = SM_LT;
               end else begin
                  role          = ROLE_TEXT;
                  nxt.scan_mode = SM_TEXT;
               end
            end
            SM_LT: begin
               if (doc_byte == CH_SLASH) nxt.scan_mode = SM_ETAG_NAME;
               else if (doc_byte == CH_BANG) nxt.scan_mode = SM_BANG;
               else if (doc_byte == CH_QUEST) nxt.scan_mode = SM_PI;
               else if (is_name_byte(doc_byte)) begin
                  role          = ROLE_START_NAME;
                  nxt.scan_mode = SM_STAG_NAME;
               end else err = 1'b1;
            end
            SM_BANG: begin
               if (doc_byte == CH_DASH) nxt.scan_mode = SM_BANG_DASH;
               else if (doc_byte == CH_GT) nxt.scan_mode = SM_OUT;
               else nxt.scan_mode = SM_DECL;
            end
            SM_BANG_DASH: begin
               if (doc_byte == CH_DASH) nxt.scan_mode = SM_COMMENT;
               else if (doc_byte == CH_GT) nxt.scan_mode = SM_OUT;
               else nxt.scan_mode = SM_DECL;
            end
            SM_COMMENT: begin
               if (doc_byte == CH_DASH) nxt.scan_mode = SM_COM_D1;
            end
            SM_COM_D1: begin
               nxt.scan_mode = (doc_byte == CH_DASH) ? SM_COM_D2 : SM_COMMENT;
            end
            SM_COM_D2: begin
               if (doc_byte == CH_GT) nxt.scan_mode = SM_OUT;
               else if (doc_byte != CH_DASH) nxt.scan_mode = SM_COMMENT;
            end
            SM_DECL: begin
               if (doc_byte == CH_GT) nxt.scan_mode = SM_OUT;
            end
            SM_PI: begin
               if (doc_byte == CH_QUEST) nxt.scan_mode = SM_PI_Q;
            end
            SM_PI_Q: begin
               if (doc_byte == CH_GT) nxt.scan_mode = SM_OUT;
               else if (doc_byte != CH_QUEST) nxt.scan_mode = SM_PI;
            end
            SM_ETAG_NAME: begin
               if (is_name_byte(doc_byte)) role = ROLE_END_NAME;
               else if (doc_byte == CH_GT) begin
                  ev            = EV_END_DONE;
                  nxt.scan_mode = SM_OUT;
               end else nxt.scan_mode = SM_ETAG_REST;
            end
            SM_ETAG_REST: begin
               if (doc_byte == CH_GT) begin
                  ev            = EV_END_DONE;
                  nxt.scan_mode = SM_OUT;
               end
            end
            SM_STAG_NAME: begin
               if (is_name_byte(doc_byte)) role = ROLE_START_NAME;
               else begin
                  role          = al_role;
                  ev            = al_ev;
                  nxt.scan_mode = al_mode;
                  err           = al_err;
               end
            end
            SM_ATTR_WS: begin
               role          = al_role;
               ev            = al_ev;
               nxt.scan_mode = al_mode;
               err           = al_err;
            end
            SM_SLASH: begin
               if (doc_byte == CH_GT) begin
                  ev            = EV_EMPTY_DONE;
                  nxt.scan_mode = SM_OUT;
               end else err = 1'b1;
            end
            SM_ANAME: begin
               if (is_name_byte(doc_byte)) role = ROLE_ATTR_NAME;
               else if (doc_byte == CH_EQ) nxt.scan_mode = SM_EQ;
               else if (is_ws(doc_byte)) nxt.scan_mode = SM_ANAME_WS;
               else err = 1'b1;
            end
            SM_ANAME_WS: begin
               if (doc_byte == CH_EQ) nxt.scan_mode = SM_EQ;
               else if (!is_ws(doc_byte)) err = 1'b1;
            end
            SM_EQ: begin
               if (doc_byte inside {CH_DQUOT, CH_SQUOT}) begin
                  nxt.quote_dbl = (doc_byte == CH_DQUOT);
                  nxt.scan_mode = SM_VALUE;
               end else if (!is_ws(doc_byte)) begin
                  ad            = 1'b1;
                  role          = al_role;
                  ev            = al_ev;
                  nxt.scan_mode = al_mode;
                  err           = al_err;
               end
            end
            SM_VALUE: begin
               if (doc_byte == (cur_state.quote_dbl ? CH_DQUOT : CH_SQUOT)) begin
                  ad            = 1'b1;
                  nxt.scan_mode = SM_ATTR_WS;
               end else role = ROLE_ATTR_VALUE;
            end
            default: begin
               nxt.scan_mode = SM_OUT;
               err           = 1'b1;
            end
         endcase

         if (!err && doc_last) begin
            if (nxt.scan_mode == SM_TEXT) ev = EV_TEXT_WITH;
            else if (nxt.scan_mode != SM_OUT) err = 1'b1;
         end
         if (err) begin
            nxt.error_seen = 1'b1;
            role           = ROLE_MARKUP;
            ad             = 1'b0;
            if (ev != EV_TEXT_BEFORE) ev = EV_NONE;
         end
         done = doc_last && !nxt.error_seen;
      end

      result.role        = role;
      result.token_event = ev;
      result.attr_done   = ad;
      result.error_flag  = nxt.error_seen;
      result.doc_done    = done;

      if (doc_last) begin
         nxt.scan_mode  = SM_OUT;
         nxt.quote_dbl  = 1'b0;
         nxt.error_seen = 1'b0;
      end
      next_state = nxt;
   end

endmodule

`default_nettype wire

### rtl/xml_markup_tokenizer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming XML markup tokenizer. One document byte enters per req beat
// (req_doc_byte, req_doc_last) and exactly one rsp beat leaves for it, in
// order: the byte echoed with its role, any token boundary event, the
// attribute-value-closed mark, the sticky error flag and the clean-end mark.
// A beat is taken on a rising edge with valid high and stall low.
// From a req beat to its rsp beat, the byte is first captured in an input
// register; the scanner state update and output register load then happen
// on the same edge, which is when rsp_valid rises.
// Throughput is one byte per cycle while the receiver does not stall, set by
// the combinational scanner state transition.
// When the receiver stalls, the result holds in the output register and one
// more byte is still taken into the input register; req_stall rises only
// when both registers are full.
// The beat marked last ends the document and returns the scanner to its
// outside-markup state with no error, ready for the next document.
// Reset (synchronous, active high) empties both registers and clears the
// scanner state.
module xml_markup_tokenizer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_doc_byte,
   input  logic       req_doc_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_byte_echo,
   output logic [2:0] rsp_role,
   output logic [2:0] rsp_token_event,
   output logic       rsp_attr_done,
   output logic       rsp_error_flag,
   output logic       rsp_doc_done
);
   import xmt_pkg::*;

   logic            in_vld_ff, in_vld_in;
   logic [7:0]      in_byte_ff;
   logic            in_last_ff;
   scan_state_type  state_ff, state_in;
   scan_result_type scan_res;
   logic            out_vld_ff, out_vld_in;
   logic [7:0]      out_byte_ff;
   scan_result_type out_res_ff;
   logic            move;

   assign move      = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !move;

   xmt_scan u_scan (
      .cur_state  (state_ff),
      .doc_byte   (in_byte_ff),
      .doc_last   (in_last_ff),
      .next_state (state_in),
      .result     (scan_res)
   );

   always_comb begin
      in_vld_in = in_vld_ff;
      if (!req_stall) in_vld_in = req_valid;
      out_vld_in = out_vld_ff;
      if (move) out_vld_in = 1'b1;
      else if (!rsp_stall) out_vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         state_ff   <= '{scan_mode: SM_OUT, quote_dbl: 1'b0, error_seen: 1'b0};
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (move) state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_doc_byte;
         in_last_ff <= req_doc_last;
      end
      if (move) begin
         out_byte_ff <= in_byte_ff;
         out_res_ff  <= scan_res;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_byte_echo   = out_byte_ff;
   assign rsp_role        = out_res_ff.role;
   assign rsp_token_event = out_res_ff.token_event;
   assign rsp_attr_done   = out_res_ff.attr_done;
   assign rsp_error_flag  = out_res_ff.error_flag;
   assign rsp_doc_done    = out_res_ff.doc_done;

endmodule

`default_nettype wire

### rtl/xmt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module xmt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_doc_byte,
   input logic       req_doc_last,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_byte_echo,
   input logic [2:0] rsp_role,
   input logic [2:0] rsp_token_event,
   input logic       rsp_attr_done,
   input logic       rsp_error_flag,
   input logic       rsp_doc_done
);
   import xmt_pkg::*;

   // An errored document reports only markup role and never a clean end.
   a_error_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_flag |->
         rsp_role == ROLE_MARKUP && !rsp_attr_done && !rsp_doc_done)
      else $error("error beat carries role, attribute close or clean end");

   // A byte that closes an attribute value has markup role or starts an attribute name.
   a_attr_role: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_attr_done |->
         rsp_role == ROLE_MARKUP || rsp_role == ROLE_ATTR_NAME)
      else $error("attribute close with unexpected role");

   // Text that ends with its own byte must be a text byte on the last beat.
   a_text_with: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_event == EV_TEXT_WITH |-> rsp_role == ROLE_TEXT)
      else $error("text end event on a non-text byte");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_byte_echo))
      else $error("stalled response beat changed");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=>
         req_valid && $stable(req_doc_byte) && $stable(req_doc_last))
      else $error("stalled request beat changed");

endmodule

bind xml_markup_tokenizer_top xmt_checker u_xmt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_doc_byte    (req_doc_byte),
   .req_doc_last    (req_doc_last),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_byte_echo   (rsp_byte_echo),
   .rsp_role        (rsp_role),
   .rsp_token_event (rsp_token_event),
   .rsp_attr_done   (rsp_attr_done),
   .rsp_error_flag  (rsp_error_flag),
   .rsp_doc_done    (rsp_doc_done)
);

`default_nettype wire
